// ----- sv/touch_button_event_processor_top_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef TOUCH_BUTTON_EVENT_PROCESSOR_TOP_MACROS_SVH
`define TOUCH_BUTTON_EVENT_PROCESSOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define TBEP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbep: implication check failed");

// cons must hold in the cycle after ante
`define TBEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbep: next-cycle check failed");

`else

`define TBEP_ASSERT_IMPL(label, ante, cons)

`define TBEP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- sv/tbep_pkg.sv -----
package tbep_pkg;

    // portrait frame defaults
    localparam int PORTRAIT_WIDTH_DEF  = 480;
    localparam int PORTRAIT_HEIGHT_DEF = 800;

    // landscape output limits (from the default 480x800 portrait frame)
    localparam int COL_MAX = 799;
    localparam int ROW_MAX = 479;

    // divisor width: 2*(max-min), max-min up to 65535
    localparam int DEN_W = 17;

    // config register indexes
    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MAX_X = 2'd1;
    localparam logic [1:0] REG_MIN_Y = 2'd2;
    localparam logic [1:0] REG_MAX_Y = 2'd3;

    // source device
    localparam logic [1:0] FUNC_BUTTON = 2'd0;
    localparam logic [1:0] FUNC_ROTARY = 2'd1;
    localparam logic [1:0] FUNC_TOUCH  = 2'd2;

    // event types
    localparam logic [4:0] EV_SYN = 5'd0;
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_REL = 5'd2;
    localparam logic [4:0] EV_ABS = 5'd3;

    // event codes
    localparam logic [9:0] CODE_SYN_REPORT = 10'd0;
    localparam logic [9:0] CODE_REL_HWHEEL = 10'd6;
    localparam logic [9:0] CODE_ABS_X      = 10'd0;
    localparam logic [9:0] CODE_ABS_Y      = 10'd1;
    localparam logic [9:0] CODE_MT_X       = 10'h035;
    localparam logic [9:0] CODE_MT_Y       = 10'h036;
    localparam logic [9:0] CODE_BTN_TOUCH  = 10'd330;
    localparam logic [9:0] CODE_BTN_TOUCH2 = 10'h145;
    localparam logic [9:0] CODE_KEY_ESC    = 10'd1;
    localparam logic [9:0] CODE_KEY_ENTER  = 10'd28;
    localparam logic [9:0] CODE_KEY_1      = 10'd2;
    localparam logic [9:0] CODE_KEY_2      = 10'd3;
    localparam logic [9:0] CODE_KEY_3      = 10'd4;
    localparam logic [9:0] CODE_KEY_4      = 10'd5;
    localparam logic [9:0] CODE_KEY_M      = 10'd50;

    typedef enum logic [2:0] {
        KIND_BTN_PRESS   = 3'd0,
        KIND_BTN_RELEASE = 3'd1,
        KIND_SCROLL      = 3'd2,
        KIND_TOUCH_PRESS = 3'd3,
        KIND_TOUCH_REL   = 3'd4,
        KIND_TOUCH_MOVE  = 3'd5
    } kind_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] id;
    } button_map_t;

    function automatic button_map_t button_of(input logic [9:0] code);
        button_map_t m;
        m.hit = 1'b1;
        m.id  = 3'd0;
        case (code)
            CODE_KEY_ESC:   m.id = 3'd0;
            CODE_KEY_ENTER: m.id = 3'd1;
            CODE_KEY_1:     m.id = 3'd2;
            CODE_KEY_2:     m.id = 3'd3;
            CODE_KEY_3:     m.id = 3'd4;
            CODE_KEY_4:     m.id = 3'd5;
            CODE_KEY_M:     m.id = 3'd6;
            default:        m.hit = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/tbep_div.sv -----
module tbep_div #(
    parameter int QUO_W = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tbep_pkg::DEN_W+QUO_W-1:0]    num,
    input  logic [tbep_pkg::DEN_W-1:0]          den,
    output logic                                done,
    output logic [QUO_W-1:0]                    quo
);
    import tbep_pkg::*;

    localparam int NUM_W = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [QUO_W-1:0] sh_reg;
    logic [QUO_W-1:0] sh_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [QUO_W:0]   sh_shift;

    // restoring division, one quotient bit per cycle; numerator low bits
    // shift out as quotient bits shift in
    always_comb
    begin
        trial    = {rem_reg, sh_reg[QUO_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        sh_shift = {sh_reg, ge};
        sh_next  = sh_shift[QUO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            sh_reg   <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                // quotient fits QUO_W bits, so the upper part is below den
                rem_reg  <= num[NUM_W-1:QUO_W];
                sh_reg   <= num[QUO_W-1:0];
                den_reg  <= den;
                cnt_reg  <= CNT_W'(QUO_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                sh_reg  <= sh_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

// ----- sv/touch_button_event_processor_top.sv -----
// Input event processor: takes one raw event per request (source, type,
// code, value) and returns at most one user event. Button, scroll and touch
// release events pass through the pending result registers and ST_EMIT to
// the output register. Touch press and touch move events rescale both axes
// through one shared multiplier and one serial divider, which yields one
// quotient bit a cycle. s_tready is low while an event is in work or its
// result waits for the output register.
`include "touch_button_event_processor_top_macros.svh"

module touch_button_event_processor_top #(
    parameter int PORTRAIT_WIDTH  = tbep_pkg::PORTRAIT_WIDTH_DEF,
    parameter int PORTRAIT_HEIGHT = tbep_pkg::PORTRAIT_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // ev_code[9:0], ev_value[41:10], zero pad
    input  logic [6:0]  s_tuser,   // func[1:0], ev_type[6:2]
    // output events
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // button_id[2:0], scroll_delta[34:3],
                                   // touch_col[44:35], touch_row[53:45],
                                   // buttons_held[60:54], touch_held[61], pad
    output logic [2:0]  m_tuser    // event_kind[2:0]
);
    import tbep_pkg::*;

    localparam int QW    = $clog2(PORTRAIT_WIDTH > PORTRAIT_HEIGHT ?
                                  PORTRAIT_WIDTH : PORTRAIT_HEIGHT);
    localparam int NUM_W = DEN_W + QW;
    localparam int PROD_W = 16 + QW;
    localparam int EW    = (QW > 10 ? QW : 10) + 1;
    localparam logic [QW-1:0] PW_M1 = QW'(PORTRAIT_WIDTH - 1);
    localparam logic [QW-1:0] PH_M1 = QW'(PORTRAIT_HEIGHT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

    // config registers
    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;

    // event state
    logic signed [31:0] raw_col_reg, raw_row_reg;
    logic               pending_reg;
    logic               touch_down_reg;
    logic [9:0]         last_col_reg;
    logic [8:0]         last_row_reg;
    logic [6:0]         held_reg;

    // sequencer
    state_t             state_reg;
    logic               axis_y_reg;
    logic               op_move_reg;
    logic [15:0]        n_reg;
    logic [15:0]        d_reg;
    logic               degen_reg;
    logic [QW-1:0]      px_reg, py_reg;

    // pending result
    kind_t              res_kind_reg;
    logic [2:0]         res_bid_reg;
    logic [31:0]        res_delta_reg;
    logic [9:0]         res_col_reg;
    logic [8:0]         res_row_reg;
    logic [6:0]         res_held_reg;
    logic               res_touch_reg;

    // output register
    logic               m_tvalid_reg;
    kind_t              out_kind_reg;
    logic [2:0]         out_bid_reg;
    logic [31:0]        out_delta_reg;
    logic [9:0]         out_col_reg;
    logic [8:0]         out_row_reg;
    logic [6:0]         out_held_reg;
    logic               out_touch_reg;

    // input fields
    logic [1:0]         func;
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
    logic               s_accept;
    logic               cfg_write;

    assign func     = s_tuser[1:0];
    assign ev_type  = s_tuser[6:2];
    assign ev_code  = s_tdata[9:0];
    assign ev_value = s_tdata[41:10];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // ---------------- config port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= 16'sd0;
            max_x_reg <= 16'sd480;
            min_y_reg <= 16'sd0;
            max_y_reg <= 16'sd800;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MIN_X: min_x_reg <= pwdata[15:0];
                REG_MAX_X: max_x_reg <= pwdata[15:0];
                REG_MIN_Y: min_y_reg <= pwdata[15:0];
                REG_MAX_Y: max_y_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MIN_X: prdata = {{16{min_x_reg[15]}}, min_x_reg};
            REG_MAX_X: prdata = {{16{max_x_reg[15]}}, max_x_reg};
            REG_MIN_Y: prdata = {{16{min_y_reg[15]}}, min_y_reg};
            REG_MAX_Y: prdata = {{16{max_y_reg[15]}}, max_y_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------- decode helpers ----------------
    button_map_t        bmap;
    logic               key_is_01;
    logic [6:0]         held_new;
    logic               is_touch_key;

    always_comb
    begin
        bmap      = button_of(ev_code);
        key_is_01 = (ev_value == 32'sd1) || (ev_value == 32'sd0);
        held_new  = held_reg;
        held_new[bmap.id] = (ev_value == 32'sd1);
        is_touch_key = (ev_code == CODE_BTN_TOUCH) || (ev_code == CODE_BTN_TOUCH2);
    end

    // ---------------- shared scaling datapath ----------------
    logic signed [31:0] sel_v;
    logic signed [15:0] sel_lo, sel_hi;
    logic signed [32:0] off;
    logic signed [16:0] span;
    logic               degen;
    logic [15:0]        n_clamp;
    logic [QW-1:0]      scale_m1;
    logic [PROD_W-1:0]  prod;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_start;
    logic               div_done;
    logic [QW-1:0]      div_quo;
    logic [QW-1:0]      quo_sel;

    always_comb
    begin
        sel_v  = axis_y_reg ? raw_row_reg : raw_col_reg;
        sel_lo = axis_y_reg ? min_y_reg : min_x_reg;
        sel_hi = axis_y_reg ? max_y_reg : max_x_reg;
        off    = 33'(sel_v) - 33'(sel_lo);
        span   = 17'(sel_hi) - 17'(sel_lo);
        degen  = span[16] || (span == 17'sd0);
        if (off[32])
            n_clamp = '0;
        else if (off > 33'(span))
            n_clamp = span[15:0];
        else
            n_clamp = off[15:0];
    end

    // 2*n*(frame size - 1) + d over 2*d gives the half-up rounded scale
    always_comb
    begin
        scale_m1  = axis_y_reg ? PH_M1 : PW_M1;
        prod      = PROD_W'(n_reg) * PROD_W'(scale_m1);
        div_num   = NUM_W'({prod, 1'b0}) + NUM_W'(d_reg);
        div_den   = {d_reg, 1'b0};
        div_start = (state_reg == ST_MUL);
        quo_sel   = degen_reg ? '0 : div_quo;
    end

    tbep_div #(
        .QUO_W (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // rotate to landscape and clamp
    logic [EW-1:0] col_full, row_full;
    logic [9:0]    new_col;
    logic [8:0]    new_row;

    always_comb
    begin
        col_full = EW'(py_reg);
        row_full = EW'(PW_M1) - EW'(px_reg);
        new_col  = (col_full > EW'(COL_MAX)) ? 10'(COL_MAX) : col_full[9:0];
        new_row  = (row_full > EW'(ROW_MAX)) ? 9'(ROW_MAX) : row_full[8:0];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            raw_col_reg    <= '0;
            raw_row_reg    <= '0;
            pending_reg    <= 1'b0;
            touch_down_reg <= 1'b0;
            last_col_reg   <= '0;
            last_row_reg   <= '0;
            held_reg       <= '0;
            axis_y_reg     <= 1'b0;
            op_move_reg    <= 1'b0;
            n_reg          <= '0;
            d_reg          <= '0;
            degen_reg      <= 1'b0;
            px_reg         <= '0;
            py_reg         <= '0;
            res_kind_reg   <= KIND_BTN_PRESS;
            res_bid_reg    <= '0;
            res_delta_reg  <= '0;
            res_col_reg    <= '0;
            res_row_reg    <= '0;
            res_held_reg   <= '0;
            res_touch_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_kind_reg   <= KIND_BTN_PRESS;
            out_bid_reg    <= '0;
            out_delta_reg  <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_held_reg   <= '0;
            out_touch_reg  <= 1'b0;
        end
        else
        begin
            // ST_EMIT reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        // result fields per source; touch press and move
                        // refill position, held and touch in ST_FIN
                        res_bid_reg   <= (func == FUNC_BUTTON) ? bmap.id : 3'd0;
                        res_delta_reg <= (func == FUNC_ROTARY) ? ev_value : 32'd0;
                        res_col_reg   <= (func == FUNC_TOUCH) ? last_col_reg : 10'd0;
                        res_row_reg   <= (func == FUNC_TOUCH) ? last_row_reg : 9'd0;
                        res_held_reg  <= (func == FUNC_BUTTON) ? held_new : held_reg;
                        res_touch_reg <= (func == FUNC_TOUCH) ? 1'b0 : touch_down_reg;
                        axis_y_reg    <= 1'b0;
                        case (func)
                            FUNC_BUTTON:
                            begin
                                if (ev_type == EV_KEY && bmap.hit && key_is_01)
                                begin
                                    held_reg     <= held_new;
                                    res_kind_reg <= (ev_value == 32'sd1) ?
                                                    KIND_BTN_PRESS : KIND_BTN_RELEASE;
                                    state_reg    <= ST_EMIT;
                                end
                            end
                            FUNC_ROTARY:
                            begin
                                if (ev_type == EV_REL && ev_code == CODE_REL_HWHEEL)
                                begin
                                    res_kind_reg  <= KIND_SCROLL;
                                    state_reg     <= ST_EMIT;
                                end
                            end
                            FUNC_TOUCH:
                            begin
                                if (ev_type == EV_ABS)
                                begin
                                    if (ev_code == CODE_ABS_X || ev_code == CODE_MT_X)
                                    begin
                                        raw_col_reg <= ev_value;
                                        pending_reg <= 1'b1;
                                    end
                                    else if (ev_code == CODE_ABS_Y || ev_code == CODE_MT_Y)
                                    begin
                                        raw_row_reg <= ev_value;
                                        pending_reg <= 1'b1;
                                    end
                                end
                                else if (ev_type == EV_KEY && is_touch_key)
                                begin
                                    if (ev_value == 32'sd1 && !touch_down_reg)
                                    begin
                                        touch_down_reg <= 1'b1;
                                        op_move_reg    <= 1'b0;
                                        state_reg      <= ST_PREP;
                                    end
                                    else if (ev_value != 32'sd1 && touch_down_reg)
                                    begin
                                        touch_down_reg <= 1'b0;
                                        res_kind_reg   <= KIND_TOUCH_REL;
                                        state_reg      <= ST_EMIT;
                                    end
                                end
                                else if (ev_type == EV_SYN && ev_code == CODE_SYN_REPORT
                                         && pending_reg)
                                begin
                                    pending_reg <= 1'b0;
                                    if (touch_down_reg)
                                    begin
                                        op_move_reg <= 1'b1;
                                        state_reg   <= ST_PREP;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                ST_PREP:
                begin
                    n_reg     <= n_clamp;
                    d_reg     <= span[15:0];
                    degen_reg <= degen;
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (axis_y_reg)
                        begin
                            py_reg    <= quo_sel;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            px_reg     <= quo_sel;
                            axis_y_reg <= 1'b1;
                            state_reg  <= ST_PREP;
                        end
                    end
                end

                ST_FIN:
                begin
                    res_col_reg   <= new_col;
                    res_row_reg   <= new_row;
                    res_touch_reg <= touch_down_reg;
                    res_held_reg  <= held_reg;
                    if (!op_move_reg)
                    begin
                        last_col_reg <= new_col;
                        last_row_reg <= new_row;
                        res_kind_reg <= KIND_TOUCH_PRESS;
                        state_reg    <= ST_EMIT;
                    end
                    else if (new_col != last_col_reg || new_row != last_row_reg)
                    begin
                        last_col_reg <= new_col;
                        last_row_reg <= new_row;
                        res_kind_reg <= KIND_TOUCH_MOVE;
                        state_reg    <= ST_EMIT;
                    end
                    else
                        state_reg <= ST_IDLE;
                end

                ST_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        out_kind_reg  <= res_kind_reg;
                        out_bid_reg   <= res_bid_reg;
                        out_delta_reg <= res_delta_reg;
                        out_col_reg   <= res_col_reg;
                        out_row_reg   <= res_row_reg;
                        out_held_reg  <= res_held_reg;
                        out_touch_reg <= res_touch_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_touch_reg, out_held_reg, out_row_reg, out_col_reg,
                       out_delta_reg, out_bid_reg};

    logic out_nontouch;
    logic btn_hit;

    assign out_nontouch = m_tvalid_reg && (out_kind_reg == KIND_BTN_PRESS ||
                          out_kind_reg == KIND_BTN_RELEASE || out_kind_reg == KIND_SCROLL);
    assign btn_hit      = s_accept && func == FUNC_BUTTON && ev_type == EV_KEY &&
                          bmap.hit && key_is_01;

    `TBEP_ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `TBEP_ASSERT_IMPL(a_fin_touch_down, state_reg == ST_FIN, touch_down_reg)
    `TBEP_ASSERT_IMPL(a_nontouch_pos_zero, out_nontouch, out_col_reg == '0 && out_row_reg == '0)
    `TBEP_ASSERT_NEXT(a_accept_leaves_idle_or_stays, btn_hit, state_reg == ST_EMIT)

endmodule

// ----- tb/sv/touch_button_event_processor_top_tb.sv -----
`timescale 1ns / 100ps

module touch_button_event_processor_top_tb;
    import tbep_pkg::*;

    localparam int FRAME_W       = PORTRAIT_WIDTH_DEF;
    localparam int FRAME_H       = PORTRAIT_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int ITEMS_PER_SET = 250;
    localparam int NUM_SETTINGS  = 6;

    typedef struct {
        kind_t       kind;
        logic [2:0]  button_id;
        logic [31:0] scroll_delta;
        logic [9:0]  touch_col;
        logic [8:0]  touch_row;
        logic [6:0]  buttons_held;
        logic        touch_held;
    } user_event_t;

    // Predicts user events from accepted requests and checks the output stream.
    class event_checker;
        user_event_t pending_events[$];
        int errors;
        int requests;
        int checked;
        int min_x, max_x, min_y, max_y;
        int raw_x, raw_y;
        bit coords_dirty, pressed;
        logic [9:0] last_col;
        logic [8:0] last_row;
        logic [6:0] held;

        function new();
            errors = 0;
            requests = 0;
            checked = 0;
            min_x = 0;
            max_x = 480;
            min_y = 0;
            max_y = 800;
            raw_x = 0;
            raw_y = 0;
            coords_dirty = 0;
            pressed = 0;
            last_col = '0;
            last_row = '0;
            held = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] v);
            int s;
            s = {{16{v[15]}}, v};
            case (idx)
                REG_MIN_X: min_x = s;
                REG_MAX_X: max_x = s;
                REG_MIN_Y: min_y = s;
                REG_MAX_Y: max_y = s;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function int map_button(logic [9:0] code);
            case (code)
                CODE_KEY_ESC:   return 0;
                CODE_KEY_ENTER: return 1;
                CODE_KEY_1:     return 2;
                CODE_KEY_2:     return 3;
                CODE_KEY_3:     return 4;
                CODE_KEY_4:     return 5;
                CODE_KEY_M:     return 6;
                default:        return -1;
            endcase
        endfunction

        // round-half-up of the clamped fraction times (span - 1)
        function longint scale_axis(int v, int lo, int hi, longint span);
            longint d, n;
            if (hi <= lo) return 0;
            d = longint'(hi) - longint'(lo);
            n = longint'(v) - longint'(lo);
            if (n < 0) n = 0;
            if (n > d) n = d;
            return (2 * n * (span - 1) + d) / (2 * d);
        endfunction

        function void locate(output logic [9:0] col, output logic [8:0] row);
            longint px, py, c, r;
            px = scale_axis(raw_x, min_x, max_x, FRAME_W);
            py = scale_axis(raw_y, min_y, max_y, FRAME_H);
            c = py;
            r = longint'(FRAME_W - 1) - px;
            if (c < 0) c = 0;
            if (c > COL_MAX) c = COL_MAX;
            if (r < 0) r = 0;
            if (r > ROW_MAX) r = ROW_MAX;
            col = c[9:0];
            row = r[8:0];
        endfunction

        function void note_request(logic [47:0] tdata, logic [6:0] tuser);
            logic [1:0]  func;
            logic [4:0]  ev_type;
            logic [9:0]  code;
            int          value;
            int          b;
            bit          hit;
            user_event_t ev;
            logic [9:0]  nc;
            logic [8:0]  nr;
            func    = tuser[1:0];
            ev_type = tuser[6:2];
            code    = tdata[9:0];
            value   = tdata[41:10];
            hit = 0;
            ev.kind = KIND_BTN_PRESS;
            ev.button_id = '0;
            ev.scroll_delta = '0;
            ev.touch_col = '0;
            ev.touch_row = '0;
            requests++;
            if (func == FUNC_BUTTON) begin
                b = map_button(code);
                if (ev_type == EV_KEY && b >= 0 && (value == 1 || value == 0)) begin
                    if (value == 1) begin
                        held[b] = 1'b1;
                        ev.kind = KIND_BTN_PRESS;
                    end
                    else begin
                        held[b] = 1'b0;
                        ev.kind = KIND_BTN_RELEASE;
                    end
                    ev.button_id = b[2:0];
                    hit = 1;
                end
            end
            else if (func == FUNC_ROTARY) begin
                if (ev_type == EV_REL && code == CODE_REL_HWHEEL) begin
                    ev.kind = KIND_SCROLL;
                    ev.scroll_delta = value;
                    hit = 1;
                end
            end
            else if (func == FUNC_TOUCH) begin
                if (ev_type == EV_ABS) begin
                    if (code == CODE_ABS_X || code == CODE_MT_X) begin
                        raw_x = value;
                        coords_dirty = 1;
                    end
                    else if (code == CODE_ABS_Y || code == CODE_MT_Y) begin
                        raw_y = value;
                        coords_dirty = 1;
                    end
                end
                else if (ev_type == EV_KEY && (code == CODE_BTN_TOUCH || code == CODE_BTN_TOUCH2))
                begin
                    if (value == 1 && !pressed) begin
                        pressed = 1;
                        locate(last_col, last_row);
                        ev.kind = KIND_TOUCH_PRESS;
                        ev.touch_col = last_col;
                        ev.touch_row = last_row;
                        hit = 1;
                    end
                    else if (value != 1 && pressed) begin
                        pressed = 0;
                        ev.kind = KIND_TOUCH_REL;
                        ev.touch_col = last_col;
                        ev.touch_row = last_row;
                        hit = 1;
                    end
                end
                else if (ev_type == EV_SYN && code == CODE_SYN_REPORT && coords_dirty) begin
                    if (pressed) begin
                        locate(nc, nr);
                        if (nc != last_col || nr != last_row) begin
                            last_col = nc;
                            last_row = nr;
                            ev.kind = KIND_TOUCH_MOVE;
                            ev.touch_col = nc;
                            ev.touch_row = nr;
                            hit = 1;
                        end
                    end
                    coords_dirty = 0;
                end
            end
            if (hit) begin
                ev.buttons_held = held;
                ev.touch_held = pressed;
                pending_events.push_back(ev);
            end
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [63:0] tdata, logic [2:0] tuser);
            user_event_t ev;
            if (pending_events.size() == 0) begin
                $error("unexpected user event: kind %0d data %h", tuser, tdata);
                errors++;
                return;
            end
            ev = pending_events.pop_front();
            checked++;
            compare_field("event_kind", longint'(ev.kind), longint'(tuser));
            compare_field("button_id", ev.button_id, tdata[2:0]);
            compare_field("scroll_delta", longint'($signed(ev.scroll_delta)),
                          longint'($signed(tdata[34:3])));
            compare_field("touch_col", ev.touch_col, tdata[44:35]);
            compare_field("touch_row", ev.touch_row, tdata[53:45]);
            compare_field("buttons_held", ev.buttons_held, tdata[60:54]);
            compare_field("touch_held", ev.touch_held, tdata[61]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [6:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    event_checker sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;
    int settings_done = 0;

    touch_button_event_processor_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_event(logic [1:0] func, logic [4:0] ev_type, logic [9:0] code,
                              logic [31:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, value, code};
        s_tuser  <= {ev_type, func};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    // wait until the block has drained, including work that yields no event
    task automatic drain();
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted request first
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_coord(int lo, int hi);
        int span;
        span = (hi > lo) ? hi - lo : 100;
        case ($urandom_range(9))
            0: return $urandom;
            1: return lo;
            2: return hi;
            3: return lo - 1 - int'($urandom_range(50));
            4: return hi + 1 + int'($urandom_range(50));
            default: return lo + int'($urandom_range(span));
        endcase
    endfunction

    function automatic logic [31:0] pick_key_value();
        if ($urandom_range(9) == 0)
            return $urandom;
        return $urandom_range(1);
    endfunction

    task automatic touch_axes();
        logic [9:0] xc, yc;
        xc = $urandom_range(1) ? CODE_MT_X : CODE_ABS_X;
        yc = $urandom_range(1) ? CODE_MT_Y : CODE_ABS_Y;
        case ($urandom_range(3))
            0: send_event(FUNC_TOUCH, EV_ABS, xc, pick_coord(sb.min_x, sb.max_x));
            1: send_event(FUNC_TOUCH, EV_ABS, yc, pick_coord(sb.min_y, sb.max_y));
            default:
            begin
                send_event(FUNC_TOUCH, EV_ABS, xc, pick_coord(sb.min_x, sb.max_x));
                send_event(FUNC_TOUCH, EV_ABS, yc, pick_coord(sb.min_y, sb.max_y));
            end
        endcase
    endtask

    task automatic touch_gesture();
        int moves;
        logic [9:0] key;
        touch_axes();
        key = $urandom_range(1) ? CODE_BTN_TOUCH2 : CODE_BTN_TOUCH;
        send_event(FUNC_TOUCH, EV_KEY, key, ($urandom_range(7) == 0) ? $urandom : 32'd1);
        moves = $urandom_range(6);
        repeat (moves)
        begin
            if ($urandom_range(7) != 0)
                touch_axes();
            send_event(FUNC_TOUCH, EV_SYN, CODE_SYN_REPORT, $urandom);
        end
        key = $urandom_range(1) ? CODE_BTN_TOUCH2 : CODE_BTN_TOUCH;
        send_event(FUNC_TOUCH, EV_KEY, key, ($urandom_range(3) == 0) ? $urandom : 32'd0);
    endtask

    task automatic random_traffic(int count);
        int first;
        int pick;
        logic [9:0] key_codes[7];
        key_codes = '{CODE_KEY_ESC, CODE_KEY_ENTER, CODE_KEY_1, CODE_KEY_2,
                      CODE_KEY_3, CODE_KEY_4, CODE_KEY_M};
        first = sb.requests;
        while (sb.requests - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                send_event(FUNC_BUTTON, EV_KEY, key_codes[$urandom_range(6)], pick_key_value());
            else if (pick < 30)
                send_event(FUNC_ROTARY, EV_REL, CODE_REL_HWHEEL,
                           $urandom_range(1) ? $urandom : 32'($signed($urandom_range(8)) - 4));
            else if (pick < 85)
                touch_gesture();
            else
                send_event(2'($urandom_range(3)), 5'($urandom_range(31)),
                           10'($urandom_range(767)), $urandom);
        end
    endtask

    task automatic directed_events();
        send_event(FUNC_BUTTON, EV_KEY, CODE_KEY_ESC, 32'd1);
        send_event(FUNC_BUTTON, EV_KEY, CODE_KEY_M, 32'd1);
        send_event(FUNC_BUTTON, EV_KEY, CODE_KEY_ENTER, 32'd2);     // not a key state
        send_event(FUNC_BUTTON, EV_KEY, 10'd767, 32'd1);            // unmapped key
        send_event(FUNC_BUTTON, EV_KEY, CODE_KEY_ESC, 32'd0);
        send_event(FUNC_ROTARY, EV_REL, CODE_REL_HWHEEL, 32'h8000_0000);
        send_event(FUNC_ROTARY, EV_REL, CODE_REL_HWHEEL, 32'h7fff_ffff);
        send_event(FUNC_ROTARY, EV_REL, 10'd7, 32'd5);
        send_event(FUNC_TOUCH, EV_ABS, CODE_ABS_X, 32'd0);
        send_event(FUNC_TOUCH, EV_ABS, CODE_ABS_Y, 32'd800);
        send_event(FUNC_TOUCH, EV_KEY, CODE_BTN_TOUCH, 32'd1);
        send_event(FUNC_TOUCH, EV_KEY, CODE_BTN_TOUCH2, 32'd1);     // already down
        send_event(FUNC_TOUCH, EV_ABS, CODE_MT_X, 32'h7fff_ffff);
        send_event(FUNC_TOUCH, EV_ABS, CODE_MT_Y, 32'h8000_0000);
        send_event(FUNC_TOUCH, EV_SYN, CODE_SYN_REPORT, 32'd0);
        send_event(FUNC_TOUCH, EV_SYN, CODE_SYN_REPORT, 32'd0);     // nothing pending
        send_event(FUNC_TOUCH, EV_ABS, CODE_ABS_X, 32'd481);        // same clamped spot
        send_event(FUNC_TOUCH, EV_SYN, CODE_SYN_REPORT, 32'd0);
        send_event(FUNC_TOUCH, EV_ABS, CODE_ABS_Y, 32'd1);
        send_event(FUNC_TOUCH, EV_SYN, CODE_SYN_REPORT, 32'd0);
        send_event(FUNC_TOUCH, EV_KEY, CODE_BTN_TOUCH2, 32'd0);
        send_event(FUNC_TOUCH, EV_KEY, CODE_BTN_TOUCH, 32'd0);      // release while idle
        send_event(2'd3, EV_KEY, CODE_KEY_ESC, 32'd1);              // unused source
        send_event(FUNC_BUTTON, 5'd31, CODE_KEY_M, 32'd0);
        send_event(FUNC_BUTTON, EV_KEY, CODE_KEY_M, 32'd0);
    endtask

    initial
    begin
        logic [15:0] ranges[NUM_SETTINGS][4];
        ranges = '{
            '{16'd0,      16'd480,    16'd0,      16'd800},
            '{16'h8000,   16'h7fff,   16'h8000,   16'h7fff},
            '{16'd100,    16'd100,    16'd500,    16'd20},     // both axes degenerate
            '{16'd3,      16'd4,      16'hfff9,   16'hfffb},
            '{16'h7fff,   16'h8000,   16'h8000,   16'h7fff},
            '{16'hfc18,   16'd3000,   16'd200,    16'd4095}
        };
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 34;
        rx_idle_pct = 48;
        directed_events();
        for (int i = 0; i < NUM_SETTINGS; i++)
        begin
            drain();
            apb_write(REG_MIN_X, ranges[i][0]);
            apb_write(REG_MAX_X, ranges[i][1]);
            apb_write(REG_MIN_Y, ranges[i][2]);
            apb_write(REG_MAX_Y, ranges[i][3]);
            case (i / 2)
                0:
                begin
                    tx_idle_pct = 34;
                    rx_idle_pct = 48;
                end
                1:
                begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 34;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            random_traffic(ITEMS_PER_SET);
            settings_done++;
        end
        drain();
        $display("summary: %0d requests, %0d user events checked, %0d range settings",
                 sb.requests, sb.checked, settings_done);
        $display("summary: buttons, scroll, touch gestures and noise under three idle patterns");
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
